// ===== rtl/button_click_long_press_fsm_assert.svh =====
// Assertion macros shared by the button detector checker.
// No dependencies; included by files that assert.
`ifndef BUTTON_CLICK_LONG_PRESS_FSM_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_FSM_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define BCLP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button detector check failed");

// next-cycle implication, disabled while reset is high
`define BCLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button detector check failed");

`endif

// ===== rtl/bclp_pkg.sv =====
// Package for the button click / long press detector: codes, widths,
// reset values and the config and result structs. No dependencies.
package bclp_pkg;

   localparam int STATE_W = 3;
   localparam int EVENT_W = 3;
   localparam int COUNT_W = 8;
   localparam int TIME_W  = 32;
   localparam int MS_W    = 16;
   localparam int CSR_IDX_W = 2;

   // machine states
   localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [STATE_W-1:0] ST_DOWN  = 3'd1;
   localparam logic [STATE_W-1:0] ST_UP    = 3'd2;
   localparam logic [STATE_W-1:0] ST_COUNT = 3'd3;
   localparam logic [STATE_W-1:0] ST_LONG  = 3'd4;
   localparam logic [STATE_W-1:0] ST_PEND  = 3'd5;

   // events
   localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_CLICK   = 3'd1;
   localparam logic [EVENT_W-1:0] EV_DOUBLE  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_LSTART  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_LDURING = 3'd4;
   localparam logic [EVENT_W-1:0] EV_LSTOP   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAXCLK   = 2'd3;

   // register reset values
   localparam logic [MS_W-1:0]    RST_DEBOUNCE = 16'd50;
   localparam logic [MS_W-1:0]    RST_CLICK    = 16'd400;
   localparam logic [MS_W-1:0]    RST_PRESS    = 16'd800;
   localparam logic [COUNT_W-1:0] RST_MAXCLK   = 8'd2;

   localparam logic [COUNT_W-1:0] ONE_CLICK  = 8'd1;
   localparam logic [COUNT_W-1:0] TWO_CLICKS = 8'd2;

   typedef struct packed {
      logic [MS_W-1:0]    debounce_ms;
      logic [MS_W-1:0]    click_ms;
      logic [MS_W-1:0]    press_ms;
      logic [COUNT_W-1:0] max_clicks;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] clicks_seen;
      logic [STATE_W-1:0] fsm_state;
      logic [EVENT_W-1:0] event_code;
   } rsp_type;

endpackage

// ===== rtl/bclp_csr.sv =====
// Configuration registers of the button detector.
// Depends on bclp_pkg.
module bclp_csr
   import bclp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [MS_W-1:0]      wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_DEBOUNCE: cfg_in.debounce_ms = wr_data;
            REG_CLICK:    cfg_in.click_ms    = wr_data;
            REG_PRESS:    cfg_in.press_ms    = wr_data;
            REG_MAXCLK:   cfg_in.max_clicks  = wr_data[COUNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= RST_DEBOUNCE;
         cfg_ff.click_ms    <= RST_CLICK;
         cfg_ff.press_ms    <= RST_PRESS;
         cfg_ff.max_clicks  <= RST_MAXCLK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bclp_fsm.sv =====
// Debounce / click / long-press state machine: state registers and the
// single-pass next-state logic. Depends on bclp_pkg.
module bclp_fsm
   import bclp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              step,
   input  logic              level,
   input  logic [TIME_W-1:0] now_ms,
   output rsp_type           result
);

   logic [STATE_W-1:0] cur_ff, cur_in;
   logic [STATE_W-1:0] prev_ff, prev_in;
   logic [TIME_W-1:0]  stamp_ff, stamp_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [EVENT_W-1:0] event_c;
   logic [TIME_W-1:0]  wait_ms;
   logic               lt_debounce;
   logic               gt_click;
   logic               gt_press;

   assign wait_ms     = now_ms - stamp_ff;
   assign lt_debounce = wait_ms < {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms};
   assign gt_click    = wait_ms > {{(TIME_W-MS_W){1'b0}}, cfg.click_ms};
   assign gt_press    = wait_ms > {{(TIME_W-MS_W){1'b0}}, cfg.press_ms};

   always_comb begin
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      stamp_in = stamp_ff;
      count_in = count_ff;
      event_c  = EV_NONE;
      unique case (cur_ff)
         ST_IDLE: begin
            if (level) begin
               prev_in  = cur_ff;
               cur_in   = ST_DOWN;
               stamp_in = now_ms;
               count_in = '0;
            end
         end
         ST_DOWN: begin
            if (!level && lt_debounce) begin
               // bounce: swap back to where we came from
               prev_in = cur_ff;
               cur_in  = prev_ff;
            end else if (!level) begin
               prev_in  = cur_ff;
               cur_in   = ST_UP;
               stamp_in = now_ms;
            end else if (gt_press) begin
               event_c = EV_LSTART;
               prev_in = cur_ff;
               cur_in  = ST_LONG;
            end
         end
         ST_UP: begin
            if (level && lt_debounce) begin
               prev_in = cur_ff;
               cur_in  = prev_ff;
            end else if (!lt_debounce) begin
               count_in = count_ff + 1'b1;
               prev_in  = cur_ff;
               cur_in   = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (level) begin
               prev_in  = cur_ff;
               cur_in   = ST_DOWN;
               stamp_in = now_ms;
            end else if (gt_click || count_ff == cfg.max_clicks) begin
               // three or more clicks end silently
               if (count_ff == ONE_CLICK) begin
                  event_c = EV_CLICK;
               end else if (count_ff == TWO_CLICKS) begin
                  event_c = EV_DOUBLE;
               end
               cur_in   = ST_IDLE;
               prev_in  = ST_IDLE;
               count_in = '0;
               stamp_in = '0;
            end
         end
         ST_LONG: begin
            if (!level) begin
               prev_in  = cur_ff;
               cur_in   = ST_PEND;
               stamp_in = now_ms;
            end else begin
               event_c = EV_LDURING;
            end
         end
         ST_PEND: begin
            if (level && lt_debounce) begin
               prev_in = cur_ff;
               cur_in  = prev_ff;
            end else if (!lt_debounce) begin
               event_c  = EV_LSTOP;
               cur_in   = ST_IDLE;
               prev_in  = ST_IDLE;
               count_in = '0;
               stamp_in = '0;
            end
         end
         default: begin
            prev_in = cur_ff;
            cur_in  = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= ST_IDLE;
         prev_ff  <= ST_IDLE;
         stamp_ff <= '0;
         count_ff <= '0;
      end else if (step) begin
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
         stamp_ff <= stamp_in;
         count_ff <= count_in;
      end
   end

   assign result.event_code  = event_c;
   assign result.fsm_state   = cur_in;
   assign result.clicks_seen = count_in;

endmodule

// ===== rtl/button_click_long_press_fsm.sv =====
// Button detector top level: request register, state machine, result register.
// Depends on bclp_pkg, bclp_csr and bclp_fsm.
//
// Each request is one poll of the button (active level plus a wrapping
// millisecond timestamp) and yields exactly one response: the event raised
// by that poll, the machine state and the click count after it. The block
// takes one request per clock cycle while the response channel is not
// stalled. A request is held in the request register, and the state-machine
// update loads the response register from it. The two registers sit around the
// single-pass next-state logic, whose longest path is the 32-bit elapsed
// time subtraction and its compare against a threshold. A stalled response
// holds the pipeline; a new request is still taken while the request stage
// is empty. Timing thresholds are written on the csr channel, which is
// always ready; writes belong in idle periods only.
module button_click_long_press_fsm
   import bclp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,  // [0] level_active, [32:1] now_ms, rest zero
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // [2:0] event_code, [5:3] fsm_state,
                                            // [13:6] clicks_seen, rest zero
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MS_W-1:0]      csr_data
);

   cfg_type           cfg;
   rsp_type           fsm_result;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_level_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff;

   logic              req_fire;
   logic              advance;
   logic              step;

   // response stage can take a new value when empty or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign step       = s1_valid_ff && advance;
   assign csr_ready  = 1'b1;

   bclp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   bclp_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .level  (s1_level_ff),
      .now_ms (s1_now_ff),
      .result (fsm_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_level_ff <= req_tdata[0];
         s1_now_ff   <= req_tdata[TIME_W:1];
      end
      if (step) begin
         out_data_ff <= fsm_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff};

endmodule

// ===== rtl/bclp_checker.sv =====
// Port-level checks for the button detector, bound to the top level.
// Depends on bclp_pkg and button_click_long_press_fsm_assert.svh.
`include "button_click_long_press_fsm_assert.svh"

module bclp_checker
   import bclp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic [EVENT_W-1:0] rsp_event;
   logic [STATE_W-1:0] rsp_state;
   logic [COUNT_W-1:0] rsp_clicks;
   logic               rsp_stall;
   logic               real_state;
   logic               long_event;
   logic               end_event;
   logic               idle_clear;

   assign rsp_event  = rsp_tdata[2:0];
   assign rsp_state  = rsp_tdata[5:3];
   assign rsp_clicks = rsp_tdata[13:6];
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign real_state = rsp_state <= ST_PEND;
   assign long_event = (rsp_event == EV_LSTART) || (rsp_event == EV_LDURING);
   assign end_event  = (rsp_event == EV_CLICK) || (rsp_event == EV_DOUBLE) ||
                       (rsp_event == EV_LSTOP);
   assign idle_clear = (rsp_state == ST_IDLE) && (rsp_clicks == '0);

   // a stalled response holds
   `BCLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // reported state is always a real state
   `BCLP_ASSERT_IMPLY(a_state_range, clock, reset, rsp_tvalid, real_state)

   // long-press start and ongoing events report the long-press state
   `BCLP_ASSERT_IMPLY(a_long_state, clock, reset, rsp_tvalid && long_event, rsp_state == ST_LONG)

   // sequence-ending events leave the machine idle with no clicks
   `BCLP_ASSERT_IMPLY(a_end_idle, clock, reset, rsp_tvalid && end_event, idle_clear)

endmodule

bind button_click_long_press_fsm bclp_checker u_bclp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
